>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> sv/bpq_pkg.sv
// ----------------------------------------------------------------------------
// bpq_pkg
// Types, constants and helpers of the bucketed priority queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

	// Queue shape
	localparam int NUM_LEVELS  = 8;
	localparam int QUEUE_DEPTH = 16;

	localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRIES = NUM_LEVELS * QUEUE_DEPTH;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int PRI_W   = 4;
	localparam int WORD_W  = 32;

	// Opcodes
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPRI = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [PRI_W-1:0]        priority_req;
		logic signed [WORD_W-1:0] data_word;
	} bpq_req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [WORD_W-1:0] front_word;
		logic [PRI_W-1:0]        front_priority;
		logic                    queue_empty;
	} bpq_rsp_t;

	// Highest occupied level
	typedef struct packed {
		logic             found;
		logic [LVL_W-1:0] idx;
	} bpq_top_t;

	// Bookkeeping result of one request
	typedef struct packed {
		logic [1:0]        status;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [ADDR_W-1:0] rd_addr;
		logic [PRI_W-1:0]  front_pri;
		logic              empty;
	} bpq_op_t;

	// Priority encoder: highest set bit wins
	function automatic bpq_top_t top_of(input logic [NUM_LEVELS-1:0] occ);
		bpq_top_t t;
		t.found = 1'b0;
		t.idx   = '0;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (occ[l]) begin
				t.found = 1'b1;
				t.idx   = LVL_W'(l);
			end
		end
		return t;
	endfunction

	// Flat storage address of one ring slot
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
		input logic [IDX_W-1:0] idx);
		return ADDR_W'(ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(idx));
	endfunction

	// Ring position advance with wrap
	function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : IDX_W'(p + 1'b1);
	endfunction

endpackage

>>> sv/bucketed_priority_queue.sv
// ----------------------------------------------------------------------------
// bucketed_priority_queue
// Priority queue with one ring FIFO per level, served highest level first.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req (opcode, priority_req, data_word) with req_valid and
//   req_stall; one response per request leaves on rsp with rsp_valid and
//   rsp_stall. A transfer happens on a rising edge with valid high and stall low.
//   Push appends data_word to level priority_req (1 to NUM_LEVELS), pop drops
//   the front word of the highest occupied level, peek and opcode three change
//   nothing. Each response reports the status and the front word and priority
//   of the highest occupied level after the request.
//   The request passes through the input register and the response register.
//   Throughput: one request per cycle while rsp_stall is low; the level
//   bookkeeping settles each request combinationally and the entry RAM serves
//   one write and one read per cycle.
//   While rsp_stall is high the response holds; one more request waits in
//   the input register, then req_stall rises.
//   Reset empties every level at once; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
module bucketed_priority_queue
	import bpq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  bpq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output bpq_rsp_t rsp
);

	logic              valid_s1;
	bpq_req_t          req_s1;
	logic              valid_s2;
	logic [1:0]        status_s2;
	logic [PRI_W-1:0]  pri_s2;
	logic              empty_s2;
	logic              fwd_s2;
	logic [WORD_W-1:0] fwd_word_s2;
	logic [WORD_W-1:0] rd_data;
	logic              advance;
	bpq_op_t           op;

	// Move the request on when the response slot is free
	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	bpq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.opcode       (req_s1.opcode),
		.priority_req (req_s1.priority_req),
		.op           (op)
	);

	bpq_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (advance && op.wr_en),
		.wr_addr (op.wr_addr),
		.wr_data (req_s1.data_word),
		.rd_en   (advance),
		.rd_addr (op.rd_addr),
		.rd_data (rd_data)
	);

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Capture status and forward a word written in the same cycle it is read
	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2   <= op.status;
			pri_s2      <= op.front_pri;
			empty_s2    <= op.empty;
			fwd_s2      <= op.wr_en && (op.wr_addr == op.rd_addr);
			fwd_word_s2 <= req_s1.data_word;
		end
	end

	// Drive the response
	assign rsp_valid          = valid_s2;
	assign rsp.status         = status_s2;
	assign rsp.front_priority = pri_s2;
	assign rsp.queue_empty    = empty_s2;
	assign rsp.front_word     = empty_s2 ? '0 : (fwd_s2 ? fwd_word_s2 : rd_data);

endmodule

>>> sv/bpq_ram.sv
// ----------------------------------------------------------------------------
// bpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read; read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> sv/bpq_ctrl.sv
// ----------------------------------------------------------------------------
// bpq_ctrl
// Per-level ring bookkeeping: counts, head and tail positions, level select.
// ----------------------------------------------------------------------------
module bpq_ctrl
	import bpq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [1:0]       opcode,
	input  logic [PRI_W-1:0] priority_req,
	output bpq_op_t          op
);

	logic [CNT_W-1:0] count_q [NUM_LEVELS];
	logic [IDX_W-1:0] head_q  [NUM_LEVELS];
	logic [IDX_W-1:0] tail_q  [NUM_LEVELS];
	logic [CNT_W-1:0] count_d [NUM_LEVELS];
	logic [IDX_W-1:0] head_d  [NUM_LEVELS];
	logic [IDX_W-1:0] tail_d  [NUM_LEVELS];

	logic [NUM_LEVELS-1:0] occ_q;
	logic [NUM_LEVELS-1:0] full_q;
	logic [NUM_LEVELS-1:0] occ_d;
	bpq_top_t              cur_top;
	bpq_top_t              nxt_top;
	logic                  pri_ok;
	logic [LVL_W-1:0]      push_lvl;
	logic                  is_push;
	logic                  is_pop;
	logic                  do_push;
	logic                  do_pop;
	logic [1:0]            status_c;

	// Decode the request against the current level state
	always_comb begin
		for (int l = 0; l < NUM_LEVELS; l++) begin
			occ_q[l]  = (count_q[l] != '0);
			full_q[l] = (count_q[l] == CNT_W'(QUEUE_DEPTH));
		end
		cur_top  = top_of(occ_q);
		pri_ok   = (priority_req != '0) && ({28'd0, priority_req} <= 32'(NUM_LEVELS));
		push_lvl = LVL_W'(priority_req - 1'b1);
		is_push  = (opcode == OP_PUSH);
		is_pop   = (opcode == OP_POP);
		do_push  = is_push && pri_ok && !full_q[push_lvl];
		do_pop   = is_pop && cur_top.found;

		if (is_push && !pri_ok) begin
			status_c = ST_BADPRI;
		end else if (is_push && full_q[push_lvl]) begin
			status_c = ST_FULL;
		end else if (is_pop && !cur_top.found) begin
			status_c = ST_EMPTY;
		end else begin
			status_c = ST_OK;
		end
	end

	// Update each level on its own
	always_comb begin
		for (int l = 0; l < NUM_LEVELS; l++) begin
			count_d[l] = count_q[l];
			head_d[l]  = head_q[l];
			tail_d[l]  = tail_q[l];
			if (do_push && (push_lvl == LVL_W'(l))) begin
				tail_d[l]  = next_pos(tail_q[l]);
				count_d[l] = CNT_W'(count_q[l] + 1'b1);
			end
			if (do_pop && (cur_top.idx == LVL_W'(l))) begin
				head_d[l]  = next_pos(head_q[l]);
				count_d[l] = CNT_W'(count_q[l] - 1'b1);
			end
			occ_d[l] = (count_d[l] != '0);
		end
		nxt_top = top_of(occ_d);
	end

	// Storage access and front of the queue after the request
	always_comb begin
		op.status    = status_c;
		op.wr_en     = do_push;
		op.wr_addr   = slot_addr(push_lvl, tail_q[push_lvl]);
		op.rd_addr   = slot_addr(nxt_top.idx, head_d[nxt_top.idx]);
		op.empty     = !nxt_top.found;
		op.front_pri = nxt_top.found ? PRI_W'({1'b0, nxt_top.idx} + 1'b1) : '0;
	end

	// Commit the level state when the request advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				count_q[l] <= '0;
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
			end
		end else if (advance) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				count_q[l] <= count_d[l];
				head_q[l]  <= head_d[l];
				tail_q[l]  <= tail_d[l];
			end
		end
	end

endmodule

>>> sv/bpq_checker.sv
// ----------------------------------------------------------------------------
// bpq_checker
// Port-level checks of the bucketed priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpq_checker
	import bpq_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input bpq_req_t req,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input bpq_rsp_t rsp
);

	// Hold a stalled response
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// Hold a stalled request
	`ASSERT_NEXT(a_req_hold, clk, arst_n, req_valid && req_stall, req_valid && $stable(req))

	// Report no front when the queue is empty
	`ASSERT_IMPLY(a_empty_front, clk, arst_n, rsp_valid && rsp.queue_empty, (rsp.front_priority == '0) && (rsp.front_word == '0))

	// A failed pop leaves the queue empty, a full level leaves it occupied
	`ASSERT_IMPLY(a_status_empty, clk, arst_n, rsp_valid && (rsp.status == ST_EMPTY), rsp.queue_empty)
	`ASSERT_IMPLY(a_status_full, clk, arst_n, rsp_valid && (rsp.status == ST_FULL), !rsp.queue_empty)

endmodule

bind bucketed_priority_queue bpq_checker u_bpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bucketed priority queue. A predictor keeps
// its own copy of every level's ring and works out the response to each
// accepted request. A checker compares each response against the oldest
// pending prediction, field by field. The tests cover directed corner cases,
// filling a level until it rejects pushes, a long receiver hold-off, and
// random traffic under several idling patterns on both sides.
// ----------------------------------------------------------------------------
module tb;
	import bpq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Opcode three is not named in the package; the block treats it as a peek
	localparam logic [1:0] OP_RSVD = 2'd3;

	logic     clk;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	bpq_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	bpq_rsp_t rsp;

	// Idling control, shared with the sender and the receiver
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int hold_left = 0;
	int err_count = 0;

	// Predicted queue contents: one ring per level
	logic signed [WORD_W-1:0] ring_mem [NUM_LEVELS][QUEUE_DEPTH];
	int ring_head [NUM_LEVELS];
	int ring_fill [NUM_LEVELS];

	bpq_rsp_t pending_rsps [$];

	bucketed_priority_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Highest occupied level, -1 when every level is empty
	function automatic int highest_level();
		int lv;
		lv = -1;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (ring_fill[l] != 0)
				lv = l;
		end
		return lv;
	endfunction

	// Apply one request to the predicted queue and build its response
	function automatic bpq_rsp_t predict_rsp(input bpq_req_t r);
		bpq_rsp_t o;
		int lv;
		o = '0;
		o.status = ST_OK;
		case (r.opcode)
			OP_PUSH: begin
				if (r.priority_req == 0 || r.priority_req > NUM_LEVELS) begin
					o.status = ST_BADPRI;
				end else begin
					lv = r.priority_req - 1;
					if (ring_fill[lv] == QUEUE_DEPTH) begin
						o.status = ST_FULL;
					end else begin
						ring_mem[lv][(ring_head[lv] + ring_fill[lv]) % QUEUE_DEPTH] = r.data_word;
						ring_fill[lv]++;
					end
				end
			end
			OP_POP: begin
				lv = highest_level();
				if (lv < 0) begin
					o.status = ST_EMPTY;
				end else begin
					ring_head[lv] = (ring_head[lv] + 1) % QUEUE_DEPTH;
					ring_fill[lv]--;
				end
			end
			default: ;
		endcase
		lv = highest_level();
		if (lv < 0) begin
			o.queue_empty = 1'b1;
		end else begin
			o.front_word     = ring_mem[lv][ring_head[lv]];
			o.front_priority = PRI_W'(lv + 1);
			o.queue_empty    = 1'b0;
		end
		return o;
	endfunction

	task automatic report_error(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	// Check each accepted response against the oldest prediction
	always @(posedge clk) begin : check_rsp
		bpq_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsps.size() == 0) begin
				report_error("response with no request outstanding");
			end else begin
				want = pending_rsps.pop_front();
				if (rsp.status !== want.status)
					report_error($sformatf("status %0d, want %0d", rsp.status, want.status));
				if (rsp.front_word !== want.front_word)
					report_error($sformatf("front_word %0d, want %0d",
						rsp.front_word, want.front_word));
				if (rsp.front_priority !== want.front_priority)
					report_error($sformatf("front_priority %0d, want %0d",
						rsp.front_priority, want.front_priority));
				if (rsp.queue_empty !== want.queue_empty)
					report_error($sformatf("queue_empty %0b, want %0b",
						rsp.queue_empty, want.queue_empty));
			end
		end
	end

	// Drive the response stall: forced hold-off first, random stalls otherwise
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
			end
		end
	end

	// Offer one request, idle first at random, and wait until it is taken
	task automatic send_req(input logic [1:0] op, input logic [PRI_W-1:0] pri,
		input logic signed [WORD_W-1:0] word);
		bpq_req_t item;
		item.opcode       = op;
		item.priority_req = pri;
		item.data_word    = word;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		pending_rsps.push_back(predict_rsp(item));
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		rsp_stall_pct = stall_pct;
	endtask

	// Corner cases: empty queue, bad priorities, extreme words, every opcode
	task automatic test_directed();
		send_req(OP_POP, 4'd0, 0);
		send_req(OP_PEEK, 4'd0, 0);
		send_req(OP_RSVD, 4'd15, -1);
		send_req(OP_PUSH, 4'd0, 32'sh1234_5678);
		send_req(OP_PUSH, 4'd9, 32'sh1234_5678);
		send_req(OP_PUSH, 4'd15, -1);
		send_req(OP_PUSH, 4'd1, 32'sh8000_0000);
		send_req(OP_PEEK, 4'd0, 0);
		send_req(OP_PUSH, 4'd8, 32'sh7FFF_FFFF);
		send_req(OP_PUSH, 4'd5, -1);
		send_req(OP_PUSH, 4'd5, 0);
		send_req(OP_PUSH, 4'd2, 32'sh5555_5555);
		send_req(OP_PUSH, 4'd7, 32'shAAAA_AAAA);
		send_req(OP_RSVD, 4'd3, 0);
		for (int i = 0; i < 6; i++)
			send_req(OP_POP, 4'd0, 0);
		send_req(OP_POP, 4'd0, 0);
		send_req(OP_PEEK, 4'd8, -1);
	endtask

	// Fill one level until it rejects a push, then wrap its ring and drain
	task automatic test_level_full();
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			send_req(OP_PUSH, 4'd3, $urandom);
		send_req(OP_PUSH, 4'd2, $urandom);
		for (int i = 0; i < QUEUE_DEPTH / 2; i++)
			send_req(OP_POP, 4'd0, 0);
		for (int i = 0; i <= QUEUE_DEPTH / 2; i++)
			send_req(OP_PUSH, 4'd3, $urandom);
		for (int i = 0; i < QUEUE_DEPTH + 3; i++)
			send_req(OP_POP, 4'd0, 0);
	endtask

	// Hold the receiver off for a long stretch while requests keep coming
	task automatic test_backpressure();
		set_idling(0, 0);
		hold_left = 200;
		for (int i = 0; i < 40; i++)
			send_req((i % 5 == 4) ? OP_PEEK : OP_PUSH, PRI_W'($urandom_range(1, NUM_LEVELS)),
				$urandom);
	endtask

	// Random traffic in blocks that alternate fill and drain bias
	task automatic test_random(input int n_items);
		int  pick;
		int  focus_a;
		int  focus_b;
		bit  filling;
		bit  focused;
		logic [1:0]       op;
		logic [PRI_W-1:0] pri;
		filling = 1'b1;
		focused = 1'b0;
		focus_a = 1;
		focus_b = 2;
		for (int i = 0; i < n_items; i++) begin
			// rotate through the idling patterns, leaving some stretches clean
			case ((i / 125) % 5)
				0: set_idling(0, 0);
				1: set_idling(78, 0);
				2: set_idling(0, 78);
				3: set_idling(32, 32);
				default: set_idling($urandom_range(0, 20), $urandom_range(0, 20));
			endcase
			// switch bias every few dozen requests
			if ($urandom_range(0, 39) == 0) begin
				filling = ~filling;
				focused = ($urandom_range(0, 1) == 1);
				focus_a = $urandom_range(1, NUM_LEVELS);
				focus_b = $urandom_range(1, NUM_LEVELS);
			end
			pick = $urandom_range(0, 99);
			if (filling)
				op = (pick < 65) ? OP_PUSH : (pick < 88) ? OP_POP : (pick < 96) ? OP_PEEK : OP_RSVD;
			else
				op = (pick < 30) ? OP_PUSH : (pick < 85) ? OP_POP : (pick < 95) ? OP_PEEK : OP_RSVD;
			if ($urandom_range(0, 99) < 8)
				pri = PRI_W'($urandom_range(0, 15));
			else if (focused)
				pri = PRI_W'(($urandom_range(0, 1) == 1) ? focus_a : focus_b);
			else
				pri = PRI_W'($urandom_range(1, NUM_LEVELS));
			send_req(op, pri, $urandom);
		end
	endtask

	// Run limit
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		for (int l = 0; l < NUM_LEVELS; l++) begin
			ring_head[l] = 0;
			ring_fill[l] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		set_idling(32, 32);
		test_level_full();
		test_backpressure();
		test_random(2000);

		// drain outstanding responses
		req_valid <= 1'b0;
		set_idling(0, 0);
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
